FILE: src/id3fs_pkg.sv
// shared types and the frame identifier table of the id3v2 frame scanner
`default_nettype none
package id3fs_pkg;

    localparam int unsigned WinLen   = 10;
    localparam int unsigned NumBases = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic        tag_ok;
        logic [27:0] tag_length;
        logic [6:0]  frame_kind;
        logic [28:0] frame_start;
        logic [27:0] frame_length;
    } t_out_item;

    typedef struct packed {
        logic       hit;
        logic [6:0] kind;
    } t_hit;

    localparam logic REC_TAG   = 1'b0;
    localparam logic REC_FRAME = 1'b1;

    // frame identifier table, index in table order
    function automatic t_hit id_lookup(input logic [31:0] id);
        t_hit r;
        r = '0;
        unique case (id)
            "AENC": r = {1'b1, 7'd0};
            "APIC": r = {1'b1, 7'd1};
            "COMM": r = {1'b1, 7'd2};
            "COMR": r = {1'b1, 7'd3};
            "ENCR": r = {1'b1, 7'd4};
            "EQUA": r = {1'b1, 7'd5};
            "ETCO": r = {1'b1, 7'd6};
            "GEOB": r = {1'b1, 7'd7};
            "GRID": r = {1'b1, 7'd8};
            "IPLS": r = {1'b1, 7'd9};
            "LINK": r = {1'b1, 7'd10};
            "MCDI": r = {1'b1, 7'd11};
            "MLLT": r = {1'b1, 7'd12};
            "OWNE": r = {1'b1, 7'd13};
            "PRIV": r = {1'b1, 7'd14};
            "PCNT": r = {1'b1, 7'd15};
            "POPM": r = {1'b1, 7'd16};
            "POSS": r = {1'b1, 7'd17};
            "RBUF": r = {1'b1, 7'd18};
            "RVAD": r = {1'b1, 7'd19};
            "RVRB": r = {1'b1, 7'd20};
            "SYLT": r = {1'b1, 7'd21};
            "SYTC": r = {1'b1, 7'd22};
            "TALB": r = {1'b1, 7'd23};
            "TBPM": r = {1'b1, 7'd24};
            "TCOM": r = {1'b1, 7'd25};
            "TCON": r = {1'b1, 7'd26};
            "TCOP": r = {1'b1, 7'd27};
            "TDAT": r = {1'b1, 7'd28};
            "TDLY": r = {1'b1, 7'd29};
            "TENC": r = {1'b1, 7'd30};
            "TEXT": r = {1'b1, 7'd31};
            "TFLT": r = {1'b1, 7'd32};
            "TIME": r = {1'b1, 7'd33};
            "TIT1": r = {1'b1, 7'd34};
            "TIT2": r = {1'b1, 7'd35};
            "TIT3": r = {1'b1, 7'd36};
            "TKEY": r = {1'b1, 7'd37};
            "TLAN": r = {1'b1, 7'd38};
            "TLEN": r = {1'b1, 7'd39};
            "TMED": r = {1'b1, 7'd40};
            "TOAL": r = {1'b1, 7'd41};
            "TOFN": r = {1'b1, 7'd42};
            "TOLY": r = {1'b1, 7'd43};
            "TOPE": r = {1'b1, 7'd44};
            "TORY": r = {1'b1, 7'd45};
            "TOWN": r = {1'b1, 7'd46};
            "TPE1": r = {1'b1, 7'd47};
            "TPE2": r = {1'b1, 7'd48};
            "TPE3": r = {1'b1, 7'd49};
            "TPE4": r = {1'b1, 7'd50};
            "TPOS": r = {1'b1, 7'd51};
            "TPUB": r = {1'b1, 7'd52};
            "TRCK": r = {1'b1, 7'd53};
            "TRDA": r = {1'b1, 7'd54};
            "TRSN": r = {1'b1, 7'd55};
            "TRSO": r = {1'b1, 7'd56};
            "TSIZ": r = {1'b1, 7'd57};
            "TSRC": r = {1'b1, 7'd58};
            "TSSE": r = {1'b1, 7'd59};
            "TYER": r = {1'b1, 7'd60};
            "TXXX": r = {1'b1, 7'd61};
            "UFID": r = {1'b1, 7'd62};
            "USER": r = {1'b1, 7'd63};
            "USLT": r = {1'b1, 7'd64};
            "WCOM": r = {1'b1, 7'd65};
            "WCOP": r = {1'b1, 7'd66};
            "WOAF": r = {1'b1, 7'd67};
            "WOAR": r = {1'b1, 7'd68};
            "WOAS": r = {1'b1, 7'd69};
            "WORS": r = {1'b1, 7'd70};
            "WPAY": r = {1'b1, 7'd71};
            "WPUB": r = {1'b1, 7'd72};
            "WXXX": r = {1'b1, 7'd73};
            "TDRC": r = {1'b1, 7'd74};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/id3v2_frame_scanner.sv
// id3v2 tag header check and frame scanner, one file byte per item
// a result is registered after its item passes the input register
// throughput: one item per cycle, set by the single input and result register pair
// a stalled result register holds the input register, which itself still takes one item
// reset: synchronous active-low, clears window, position and scan state
// a final byte of a file returns all scan state to its reset values
`default_nettype none
module id3v2_frame_scanner
    import id3fs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_out_item
);

    localparam logic [28:0] PosMax = '1;

    function automatic logic [27:0] size7(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3);
        return {b0[6:0], b1[6:0], b2[6:0], b3[6:0]};
    endfunction

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [7:0]  r_win [WinLen];
    logic [7:0]  n_win [WinLen];
    t_hit        r_hit [NumBases];
    t_hit        n_hit [NumBases];
    logic [28:0] r_pos;
    logic [28:0] n_pos;
    logic [28:0] r_nsp;
    logic [28:0] n_nsp;
    logic [28:0] r_tag_end;
    logic [28:0] n_tag_end;
    logic [27:0] r_tag_size;
    logic [27:0] n_tag_size;
    logic        r_tag_ok;
    logic        n_tag_ok;
    logic        r_done;
    logic        n_done;

    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        n_emit;

    logic        adv;
    logic        hdr_ok;
    logic [27:0] hdr_size;
    logic [27:0] full_size;
    logic        scan;
    logic        final_step;
    logic [29:0] off;
    logic        off_small;
    logic [28:0] s0;
    logic [29:0] nx;
    logic        found;
    logic [2:0]  sel;
    t_hit        sel_hit;

    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign o_valid = r_out_valid;
    assign o_out_item = r_out;

    always_comb begin
        for (int i = 0; i < WinLen - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[WinLen - 1] = r_in_byte;
        for (int b = 0; b < NumBases - 1; b++) begin
            n_hit[b] = r_hit[b + 1];
        end
        n_hit[NumBases - 1] = id_lookup({r_win[7], r_win[8], r_win[9], r_in_byte});
    end

    always_comb begin
        hdr_ok     = (n_win[0] == "I") && (n_win[1] == "D") && (n_win[2] == "3");
        hdr_size   = size7(n_win[6], n_win[7], n_win[8], n_win[9]);
        full_size  = size7(n_win[4], n_win[5], n_win[6], n_win[7]);
        scan       = r_tag_ok && !r_done && (r_pos > 29'd9);
        final_step = r_in_last || (({1'b0, r_pos} + 30'd1) == {1'b0, r_tag_end});
        off        = {1'b0, r_nsp} + 30'd9 - {1'b0, r_pos};
        off_small  = (off[29:3] == '0);
        s0         = r_pos - 29'd9;
        nx         = {1'b0, r_pos} + 30'd1 + {2'b0, full_size};

        found   = 1'b0;
        sel     = '0;
        sel_hit = '0;
        for (int b = 0; b < NumBases; b++) begin
            if (!found && off_small && (off[2:0] <= 3'(b)) && n_hit[b].hit
                && (b == 0 || final_step)) begin
                found   = 1'b1;
                sel     = 3'(b);
                sel_hit = n_hit[b];
            end
        end
    end

    always_comb begin
        n_pos      = (r_pos < PosMax) ? r_pos + 29'd1 : r_pos;
        n_nsp      = r_nsp;
        n_tag_end  = r_tag_end;
        n_tag_size = r_tag_size;
        n_tag_ok   = r_tag_ok;
        n_done     = r_done;
        n_emit     = 1'b0;
        n_out      = '0;

        if (r_pos == 29'd9) begin
            n_emit           = 1'b1;
            n_out.record_kind = REC_TAG;
            n_out.tag_ok     = hdr_ok;
            n_out.tag_length = hdr_size;
            n_tag_ok         = hdr_ok;
            n_tag_size       = hdr_size;
            n_tag_end        = hdr_ok ? 29'd10 + {1'b0, hdr_size} : '0;
            n_done           = !hdr_ok || (hdr_size == '0);
        end else if (r_pos < 29'd9) begin
            if (r_in_last) begin
                n_emit            = 1'b1;
                n_out.record_kind = REC_TAG;
            end
        end else if (scan) begin
            if (found) begin
                n_emit             = 1'b1;
                n_out.record_kind  = REC_FRAME;
                n_out.tag_ok       = 1'b1;
                n_out.tag_length   = r_tag_size;
                n_out.frame_kind   = sel_hit.kind;
                n_out.frame_start  = s0 + {26'd0, sel};
                if (sel == '0) begin
                    n_out.frame_length = full_size;
                    if (nx >= {1'b0, r_tag_end}) begin
                        n_nsp  = r_tag_end;
                        n_done = 1'b1;
                    end else begin
                        n_nsp = nx[28:0];
                    end
                end else begin
                    n_done = 1'b1;
                end
            end else if (off == '0) begin
                n_nsp = r_nsp + 29'd1;
            end
            if (final_step) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= n_emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_item.data_byte;
            r_in_last <= i_in_item.last_byte;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    // scan state, cleared again after the final byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            for (int i = 0; i < WinLen; i++) begin
                r_win[i] <= '0;
            end
            for (int b = 0; b < NumBases; b++) begin
                r_hit[b] <= '0;
            end
            r_pos      <= '0;
            r_nsp      <= 29'd10;
            r_tag_end  <= '0;
            r_tag_size <= '0;
            r_tag_ok   <= 1'b0;
            r_done     <= 1'b0;
        end else if (adv) begin
            r_win      <= n_win;
            r_hit      <= n_hit;
            r_pos      <= n_pos;
            r_nsp      <= n_nsp;
            r_tag_end  <= n_tag_end;
            r_tag_size <= n_tag_size;
            r_tag_ok   <= n_tag_ok;
            r_done     <= n_done;
        end
    end

endmodule
`default_nettype wire
